// ----- rtl/skis_pkg.sv -----
// Shared types, sizes and codes for the sorted key index search block.
// Used by every module of the block; depends on nothing.
package skis_pkg;

    localparam int INDEX_ENTRIES     = 64;
    localparam int CLIENT_KEY_BYTES  = 8;
    localparam int VEHICLE_KEY_BYTES = 8;

    localparam int CODE_W    = 64;
    localparam int OFFSET_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 7;
    localparam int IDX_W     = $clog2(INDEX_ENTRIES);
    localparam int CNT_W     = $clog2(INDEX_ENTRIES + 1);

    localparam int TREE_SHIFT  = 3;
    localparam int TREE_FANIN  = 1 << TREE_SHIFT;
    localparam int TREE_GROUPS = (INDEX_ENTRIES + TREE_FANIN - 1) / TREE_FANIN;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                command;
        logic [CODE_W-1:0]   client_code;
        logic [CODE_W-1:0]   vehicle_code;
        logic [OFFSET_W-1:0] record_offset;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OFFSET_W-1:0]  found_offset;
        logic [ENTRIES_W-1:0] entries_held;
    } out_t;

    typedef struct packed {
        logic [CODE_W-1:0]   client_code;
        logic [CODE_W-1:0]   vehicle_code;
        logic [OFFSET_W-1:0] offset;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic shift_in;
        logic load_new;
    } cell_ctl_t;

    // Keeps the leading nbytes bytes and clears everything from the first zero byte on.
    function automatic logic [CODE_W-1:0] norm_key(input logic [CODE_W-1:0] raw,
                                                   input int unsigned nbytes);
        logic [CODE_W-1:0] res;
        logic              alive;
        res   = '0;
        alive = 1'b1;
        for (int k = 0; k < 8; k++) begin
            if (k >= nbytes || raw[56-8*k +: 8] == 8'h00) begin
                alive = 1'b0;
            end
            if (alive) begin
                res[56-8*k +: 8] = raw[56-8*k +: 8];
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/skis_cell.sv -----
// One slot of the sorted index: holds an entry and its compare flags.
// Depends on skis_pkg for the entry and control types.
module skis_cell (
    input  logic               aclk,
    input  skis_pkg::cell_ctl_t ctl,
    input  skis_pkg::entry_t   new_entry,
    input  skis_pkg::entry_t   left_entry,
    output skis_pkg::entry_t   entry,
    output logic               gt,
    output logic               eq
);

    skis_pkg::entry_t entry_reg;
    logic             gt_reg;
    logic             eq_reg;

    logic [2*skis_pkg::CODE_W-1:0] own_key;
    logic [2*skis_pkg::CODE_W-1:0] probe_key;

    assign own_key   = {entry_reg.client_code, entry_reg.vehicle_code};
    assign probe_key = {new_entry.client_code, new_entry.vehicle_code};

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            gt_reg <= own_key > probe_key;
            eq_reg <= own_key == probe_key;
        end
        if (ctl.shift_in) begin
            entry_reg <= left_entry;
        end else if (ctl.load_new) begin
            entry_reg <= new_entry;
        end
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule

// ----- rtl/skis_read_tree.sv -----
// Two-level registered selector that reads the offset of one slot.
// Depends on skis_pkg for sizes.
module skis_read_tree (
    input  logic                          aclk,
    input  logic [skis_pkg::IDX_W-1:0]    sel_idx,
    input  logic [skis_pkg::OFFSET_W-1:0] offsets [skis_pkg::INDEX_ENTRIES],
    output logic [skis_pkg::OFFSET_W-1:0] rd_data
);

    logic [skis_pkg::OFFSET_W-1:0] grp_reg  [skis_pkg::TREE_GROUPS];
    logic [skis_pkg::OFFSET_W-1:0] grp_next [skis_pkg::TREE_GROUPS];
    logic [skis_pkg::OFFSET_W-1:0] rd_reg;
    logic [skis_pkg::OFFSET_W-1:0] rd_next;

    always_comb begin
        for (int g = 0; g < skis_pkg::TREE_GROUPS; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < skis_pkg::TREE_FANIN; j++) begin
                if (g * skis_pkg::TREE_FANIN + j < skis_pkg::INDEX_ENTRIES) begin
                    if (sel_idx == skis_pkg::IDX_W'(g * skis_pkg::TREE_FANIN + j)) begin
                        grp_next[g] = offsets[g * skis_pkg::TREE_FANIN + j];
                    end
                end
            end
        end
    end

    always_comb begin
        rd_next = '0;
        for (int g = 0; g < skis_pkg::TREE_GROUPS; g++) begin
            if ((sel_idx >> skis_pkg::TREE_SHIFT) == skis_pkg::IDX_W'(g)) begin
                rd_next = grp_reg[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
        rd_reg  <= rd_next;
    end

    assign rd_data = rd_reg;

endmodule

// ----- rtl/sorted_key_index_search.sv -----
// Sorted key index: a row of slot cells plus the command sequencer and result register.
// Depends on skis_pkg, skis_cell and skis_read_tree.
// An insert runs from acceptance through a compare state in which every cell checks its
// key against the new one, a shift state in which the row shifts up and the new entry
// drops into place, and a response state, then back to idle for the next acceptance. An
// insert into a full table skips the shift. A search runs the compare state and then P
// binary search probes (at most log2(INDEX_ENTRIES) + 1), one probe per cycle over the
// compare flags latched in the cells. A hit adds an offset read through S_RD1 and S_RD2,
// and a miss adds a step that ends the search. A result may wait at the output while the
// next item is taken, and the response state stalls until that waiting result has been
// accepted.
module sorted_key_index_search (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  skis_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output skis_pkg::out_t m_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CMP  = 7'b0000010,
        S_INS  = 7'b0000100,
        S_SRCH = 7'b0001000,
        S_RD1  = 7'b0010000,
        S_RD2  = 7'b0100000,
        S_RESP = 7'b1000000
    } state_t;

    localparam int N = skis_pkg::INDEX_ENTRIES;

    state_t                         state_reg, state_next;
    logic                           cmd_reg;
    skis_pkg::entry_t               key_reg;
    logic [skis_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [skis_pkg::CNT_W-1:0]     lo_reg, lo_next;
    logic [skis_pkg::CNT_W-1:0]     top_reg, top_next;
    logic [skis_pkg::IDX_W-1:0]     sel_reg, sel_next;
    logic [skis_pkg::STATUS_W-1:0]  res_reg, res_next;
    logic                           m_valid_reg;
    skis_pkg::out_t                 m_data_reg;

    skis_pkg::entry_t               cell_entry [N];
    skis_pkg::cell_ctl_t            cell_ctl   [N];
    logic [skis_pkg::OFFSET_W-1:0]  cell_off   [N];
    logic [N-1:0]                   gt_vec;
    logic [N-1:0]                   eq_vec;
    logic [N-1:0]                   g_vec;
    logic [skis_pkg::OFFSET_W-1:0]  rd_data;

    logic [skis_pkg::CNT_W:0]       mid_sum;
    logic [skis_pkg::CNT_W-1:0]     mid;
    logic                           out_free;

    for (genvar k = 0; k < N; k++) begin : g_cells
        assign g_vec[k]    = gt_vec[k] && (count_reg > skis_pkg::CNT_W'(k));
        assign cell_off[k] = cell_entry[k].offset;

        if (k == 0) begin : g_head
            assign cell_ctl[k].shift_in = 1'b0;
            assign cell_ctl[k].load_new = (state_reg == S_INS) && (g_vec[k] || count_reg == '0);
        end else begin : g_body
            assign cell_ctl[k].shift_in = (state_reg == S_INS) && g_vec[k-1]
                                          && (count_reg >= skis_pkg::CNT_W'(k));
            assign cell_ctl[k].load_new = (state_reg == S_INS) && !g_vec[k-1]
                                          && (count_reg >= skis_pkg::CNT_W'(k))
                                          && (g_vec[k] || count_reg == skis_pkg::CNT_W'(k));
        end
        assign cell_ctl[k].capture = (state_reg == S_CMP);

        skis_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl[k]),
            .new_entry  (key_reg),
            .left_entry ((k == 0) ? key_reg : cell_entry[(k == 0) ? 0 : k-1]),
            .entry      (cell_entry[k]),
            .gt         (gt_vec[k]),
            .eq         (eq_vec[k])
        );
    end

    skis_read_tree u_read_tree (
        .aclk    (aclk),
        .sel_idx (sel_reg),
        .offsets (cell_off),
        .rd_data (rd_data)
    );

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, top_reg} - 1'b1;
    assign mid      = mid_sum[skis_pkg::CNT_W:1];
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        top_next   = top_reg;
        sel_next   = sel_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (cmd_reg == skis_pkg::CMD_SEARCH) begin
                    lo_next    = '0;
                    top_next   = count_reg;
                    state_next = S_SRCH;
                end else if (count_reg == skis_pkg::CNT_W'(N)) begin
                    res_next   = skis_pkg::ST_FULL;
                    state_next = S_RESP;
                end else begin
                    state_next = S_INS;
                end
            end
            S_INS: begin
                count_next = count_reg + 1'b1;
                res_next   = skis_pkg::ST_INSERTED;
                state_next = S_RESP;
            end
            S_SRCH: begin
                if (lo_reg >= top_reg) begin
                    res_next   = skis_pkg::ST_NOT_FOUND;
                    state_next = S_RESP;
                end else if (eq_vec[mid[skis_pkg::IDX_W-1:0]]) begin
                    sel_next   = mid[skis_pkg::IDX_W-1:0];
                    res_next   = skis_pkg::ST_FOUND;
                    state_next = S_RD1;
                end else if (gt_vec[mid[skis_pkg::IDX_W-1:0]]) begin
                    top_next = mid;
                end else begin
                    lo_next = mid + 1'b1;
                end
            end
            S_RD1: begin
                state_next = S_RD2;
            end
            S_RD2: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        top_reg <= top_next;
        sel_reg <= sel_next;
        res_reg <= res_next;
        if (s_valid && s_ready) begin
            cmd_reg              <= s_data.command;
            key_reg.client_code  <= skis_pkg::norm_key(s_data.client_code,
                                                       skis_pkg::CLIENT_KEY_BYTES);
            key_reg.vehicle_code <= skis_pkg::norm_key(s_data.vehicle_code,
                                                       skis_pkg::VEHICLE_KEY_BYTES);
            key_reg.offset       <= s_data.record_offset;
        end
        if (state_reg == S_RESP && out_free) begin
            m_data_reg.status       <= res_reg;
            m_data_reg.found_offset <= (res_reg == skis_pkg::ST_FOUND) ? rd_data : '0;
            m_data_reg.entries_held <= skis_pkg::ENTRIES_W'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/skis_checker.sv -----
// Port-level checks for the sorted key index search block, bound to its top level.
// Depends on skis_pkg and on sorted_key_index_search.
module skis_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input skis_pkg::out_t m_data
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid seen right after reset.");

    a_stalled_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result item changed or vanished.");

    a_offset_only_when_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != skis_pkg::ST_FOUND |-> m_data.found_offset == '0)
        else $error("Nonzero offset on a result that is not a hit.");

    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == skis_pkg::ST_INSERTED |-> m_data.entries_held != '0)
        else $error("Insert reported with an empty index.");

    a_full_at_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == skis_pkg::ST_FULL
        |-> m_data.entries_held == skis_pkg::ENTRIES_W'(skis_pkg::INDEX_ENTRIES))
        else $error("Table full reported below capacity.");

endmodule

bind sorted_key_index_search skis_checker u_skis_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- bench/tb_sorted_key_index_search.sv -----
// Self-checking testbench for sorted_key_index_search: directed index and search items,
// then random insert and lookup traffic checked against a sorted-table predictor.
// Depends on skis_pkg and the sorted_key_index_search RTL.
module tb_sorted_key_index_search;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 650;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        skis_pkg::in_t  item;
        bit             typed;
        skis_pkg::out_t want;
    } vector_row_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    skis_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    skis_pkg::out_t m_data;

    bit             cur_typed = 1'b0;
    skis_pkg::out_t cur_want  = '0;
    bit             calm      = 1'b0;
    int             quiet_cycles = 0;
    int             mismatches   = 0;

    logic [127:0] held_key    [skis_pkg::INDEX_ENTRIES];
    logic [31:0]  held_offset [skis_pkg::INDEX_ENTRIES];
    int           held_count = 0;

    skis_pkg::out_t lookup_results_q[$];
    logic [127:0]   key_pool[$];
    vector_row_t    dir_rows[$];

    sorted_key_index_search i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    function automatic logic [63:0] key_prefix(input logic [63:0] raw, input int nbytes);
        logic [63:0] res;
        bit          ended;
        res   = '0;
        ended = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (k >= nbytes || raw[56-8*k +: 8] == 8'h00) begin
                ended = 1'b1;
            end
            if (!ended) begin
                res[56-8*k +: 8] = raw[56-8*k +: 8];
            end
        end
        return res;
    endfunction

    function automatic skis_pkg::out_t index_step(input skis_pkg::in_t it);
        logic [127:0]   k;
        skis_pkg::out_t r;
        int             pos;
        int             lo;
        int             hi;
        int             mid;
        bit             hit;
        k = {key_prefix(it.client_code, skis_pkg::CLIENT_KEY_BYTES),
             key_prefix(it.vehicle_code, skis_pkg::VEHICLE_KEY_BYTES)};
        r = '0;
        if (it.command == skis_pkg::CMD_INSERT) begin
            if (held_count >= skis_pkg::INDEX_ENTRIES) begin
                r.status = skis_pkg::ST_FULL;
            end else begin
                pos = held_count;
                for (int i = held_count - 1; i >= 0; i--) begin
                    if (held_key[i] > k) begin
                        pos = i;
                    end
                end
                for (int i = held_count; i > pos; i--) begin
                    held_key[i]    = held_key[i-1];
                    held_offset[i] = held_offset[i-1];
                end
                held_key[pos]    = k;
                held_offset[pos] = it.record_offset;
                held_count++;
                r.status = skis_pkg::ST_INSERTED;
            end
        end else begin
            lo       = 0;
            hi       = held_count - 1;
            hit      = 1'b0;
            r.status = skis_pkg::ST_NOT_FOUND;
            while (!hit && lo <= hi) begin
                mid = (lo + hi) / 2;
                if (held_key[mid] == k) begin
                    hit            = 1'b1;
                    r.status       = skis_pkg::ST_FOUND;
                    r.found_offset = held_offset[mid];
                end else if (held_key[mid] < k) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        r.entries_held = skis_pkg::ENTRIES_W'(held_count);
        return r;
    endfunction

    function automatic logic [63:0] ascii_code(input int min_len, input int max_len,
                                               input int letters);
        logic [63:0] code;
        int          len;
        code = '0;
        len  = $urandom_range(max_len, min_len);
        for (int k = 0; k < len; k++) begin
            code[56-8*k +: 8] = 8'h41 + 8'($urandom_range(letters - 1, 0));
        end
        return code;
    endfunction

    function automatic logic [63:0] smear_tail(input logic [63:0] code);
        bit ended;
        ended = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (ended) begin
                code[56-8*k +: 8] = 8'($urandom);
            end else if (code[56-8*k +: 8] == 8'h00) begin
                ended = 1'b1;
            end
        end
        return code;
    endfunction

    function automatic skis_pkg::in_t random_item();
        skis_pkg::in_t it;
        logic [127:0]  k;
        int            roll;
        it.command       = ($urandom_range(99, 0) < 45) ? skis_pkg::CMD_INSERT
                                                        : skis_pkg::CMD_SEARCH;
        it.record_offset = $urandom;
        roll             = $urandom_range(99, 0);
        if (roll < 10) begin
            k = {$urandom, $urandom, $urandom, $urandom};
        end else if (key_pool.size() > 0
                     && roll < (it.command == skis_pkg::CMD_SEARCH ? 80 : 35)) begin
            k = key_pool[$urandom_range(key_pool.size() - 1, 0)];
        end else begin
            k = {ascii_code(1, 3, 3), ascii_code(0, 4, 4)};
        end
        if ($urandom_range(99, 0) < 30) begin
            k = {smear_tail(k[127:64]), smear_tail(k[63:0])};
        end
        if (it.command == skis_pkg::CMD_INSERT) begin
            key_pool.push_back(k);
        end
        it.client_code  = k[127:64];
        it.vehicle_code = k[63:0];
        return it;
    endfunction

    function automatic void add_row(input logic cmd, input logic [63:0] client,
                                    input logic [63:0] vehicle, input logic [31:0] offset,
                                    input bit typed, input logic [1:0] status,
                                    input logic [31:0] found, input logic [6:0] held);
        vector_row_t row;
        row.item  = '{cmd, client, vehicle, offset};
        row.typed = typed;
        row.want  = '{status, found, held};
        dir_rows.push_back(row);
    endfunction

    task automatic send(input skis_pkg::in_t item, input bit typed,
                        input skis_pkg::out_t want);
        if (!calm && $urandom_range(99, 0) < 20) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99, 0) < 20);
        end
        s_valid   <= 1'b1;
        s_data    <= item;
        cur_typed <= typed;
        cur_want  <= want;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        skis_pkg::out_t predicted;
        if (aresetn && s_valid && s_ready) begin
            predicted = index_step(s_data);
            lookup_results_q.push_back(cur_typed ? cur_want : predicted);
        end
    end

    always @(posedge aclk) begin
        skis_pkg::out_t want;
        m_ready <= calm || ($urandom_range(99, 0) >= 20);
        if (aresetn && m_valid && m_ready) begin
            if (lookup_results_q.size() == 0) begin
                $error("result item with no expectation waiting: status %0d", m_data.status);
                mismatches++;
            end else begin
                want = lookup_results_q.pop_front();
                check_field("status", 32'(want.status), 32'(m_data.status));
                check_field("found_offset", want.found_offset, m_data.found_offset);
                check_field("entries_held", 32'(want.entries_held), 32'(m_data.entries_held));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
        end
        $display("sorted_key_index_search regression: fail");
        $finish;
    end

    initial begin
        add_row(skis_pkg::CMD_SEARCH, '1, '1, 32'h0,
                1'b1, skis_pkg::ST_NOT_FOUND, 32'h0, 7'd0);
        add_row(skis_pkg::CMD_INSERT, '0, '0, 32'h0,
                1'b1, skis_pkg::ST_INSERTED, 32'h0, 7'd1);
        add_row(skis_pkg::CMD_SEARCH, '0, '0, 32'h0,
                1'b1, skis_pkg::ST_FOUND, 32'h0, 7'd1);
        add_row(skis_pkg::CMD_INSERT, '1, '1, '1,
                1'b1, skis_pkg::ST_INSERTED, 32'h0, 7'd2);
        add_row(skis_pkg::CMD_SEARCH, '1, '1, 32'h0,
                1'b1, skis_pkg::ST_FOUND, 32'hFFFF_FFFF, 7'd2);
        add_row(skis_pkg::CMD_SEARCH, '1, '0, '1,
                1'b1, skis_pkg::ST_NOT_FOUND, 32'h0, 7'd2);
        add_row(skis_pkg::CMD_INSERT, 64'h4142_4300_0000_0000, 64'h4341_5231_0000_0000,
                32'h1000, 1'b1, skis_pkg::ST_INSERTED, 32'h0, 7'd3);
        add_row(skis_pkg::CMD_INSERT, 64'h4142_0055_AA00_0000, 64'h5600_FFFF_FFFF_FFFF,
                32'hA5A5_5A5A, 1'b1, skis_pkg::ST_INSERTED, 32'h0, 7'd4);
        add_row(skis_pkg::CMD_SEARCH, 64'h4142_0000_0000_0000, 64'h5600_0000_0000_0000,
                32'h0, 1'b0, '0, 32'h0, 7'd0);
        add_row(skis_pkg::CMD_SEARCH, 64'h4142_00FF_FFFF_FFFF, 64'h5600_1234_5678_9ABC,
                32'h0, 1'b0, '0, 32'h0, 7'd0);
        add_row(skis_pkg::CMD_INSERT, 64'h4142_4300_0000_0000, 64'h4341_5231_0000_0000,
                32'h2000, 1'b1, skis_pkg::ST_INSERTED, 32'h0, 7'd5);
        add_row(skis_pkg::CMD_INSERT, 64'h4142_4300_0000_0000, 64'h4341_5231_0000_0000,
                32'h3000, 1'b1, skis_pkg::ST_INSERTED, 32'h0, 7'd6);
        add_row(skis_pkg::CMD_SEARCH, 64'h4142_4300_0000_0000, 64'h4341_5231_0000_0000,
                32'h0, 1'b0, '0, 32'h0, 7'd0);
        add_row(skis_pkg::CMD_INSERT, 64'h4142_4300_0000_0000, 64'h4341_5230_0000_0000,
                32'h4000, 1'b1, skis_pkg::ST_INSERTED, 32'h0, 7'd7);
        add_row(skis_pkg::CMD_INSERT, 64'h4142_4300_0000_0000, 64'h4341_5232_0000_0000,
                32'h5000, 1'b1, skis_pkg::ST_INSERTED, 32'h0, 7'd8);
        add_row(skis_pkg::CMD_SEARCH, 64'h4142_4300_0000_0000, 64'h4341_5230_0000_0000,
                32'h0, 1'b0, '0, 32'h0, 7'd0);
        add_row(skis_pkg::CMD_SEARCH, 64'h4142_4300_0000_0000, 64'h4341_5232_0000_0000,
                32'h0, 1'b0, '0, 32'h0, 7'd0);
        add_row(skis_pkg::CMD_SEARCH, 64'h4142_4300_0000_0000, 64'h4341_5233_0000_0000,
                '1, 1'b1, skis_pkg::ST_NOT_FOUND, 32'h0, 7'd8);
        add_row(skis_pkg::CMD_INSERT, 64'h0000_0000_0000_0000, 64'h5800_0000_0000_0000,
                32'h0F0F_0F0F, 1'b1, skis_pkg::ST_INSERTED, 32'h0, 7'd9);
        add_row(skis_pkg::CMD_SEARCH, 64'h00FF_FFFF_FFFF_FFFF, 64'h5800_0000_0000_0000,
                32'h0, 1'b0, '0, 32'h0, 7'd0);
        add_row(skis_pkg::CMD_SEARCH, 64'h00FF_FFFF_FFFF_FFFF, 64'h00FF_FFFF_FFFF_FFFF,
                32'h0, 1'b0, '0, 32'h0, 7'd0);
        add_row(skis_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                32'h8000_0001, 1'b1, skis_pkg::ST_INSERTED, 32'h0, 7'd10);
        add_row(skis_pkg::CMD_SEARCH, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000,
                32'h0, 1'b0, '0, 32'h0, 7'd0);
        add_row(skis_pkg::CMD_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
                32'h0, 1'b0, '0, 32'h0, 7'd0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 250 && n < 400);
            send(random_item(), 1'b0, '0);
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (lookup_results_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && lookup_results_q.size() == 0) begin
            $display("sorted_key_index_search regression: pass");
        end else begin
            $display("sorted_key_index_search regression: fail");
        end
        $finish;
    end

endmodule
